[hdl/sab_pkg.sv]
// shared constants and types for the subtitle yuv alpha blend unit
// no dependencies; used by the top level and the port checker

package sab_pkg;

    // number of coverage lanes wired into the chroma sum (1..4)
    localparam int COVER_LANES = 4;

    localparam int NUM_LAYERS = 4;
    localparam int ADDR_W     = 5;
    localparam int LATENCY    = 6;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_LAYER0 = 3'd0;
    localparam logic [2:0] REG_LAYER1 = 3'd1;
    localparam logic [2:0] REG_LAYER2 = 3'd2;
    localparam logic [2:0] REG_LAYER3 = 3'd3;
    localparam logic [2:0] REG_SHIFT  = 3'd4;

    // plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // q0.16 colour conversion coefficients
    localparam logic [15:0] Q_KR = 16'd19595;
    localparam logic [15:0] Q_KG = 16'd38470;
    localparam logic [15:0] Q_KB = 16'd7471;
    localparam logic [15:0] Q_KU = 16'd46727;
    localparam logic [15:0] Q_KV = 16'd36962;

    localparam logic signed [26:0] CHROMA_BIAS = 27'sd8388608;

    typedef logic [31:0] t_colour;

endpackage

[hdl/subtitle_yuv_alpha_blend_unit.sv]
// subtitle yuv alpha blend: layer colour to y/u/v, coverage scaling and sample mix
// depends on sab_pkg

//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  request   | i_plane i_layer i_dest_sample i_cover_a..d | start high, busy low
//  result    | o_blended_sample                           | o_valid strobe, one cycle
//  config    | psel penable pwrite paddr pwdata prdata    | apb write, pready tied high
//
// one request per clock; each result is carried to o_blended_sample by
// the six register stages (operand select, products, luma, chroma
// product, mix products, output). busy is always low. reset clears the
// valid chain and the registers (layer colours 0, chroma shift 1). results
// cannot be held off, so nothing in the pipe ever waits.

module subtitle_yuv_alpha_blend_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_plane,
    input  logic [1:0]                  i_layer,
    input  logic [7:0]                  i_dest_sample,
    input  logic [7:0]                  i_cover_a,
    input  logic [7:0]                  i_cover_b,
    input  logic [7:0]                  i_cover_c,
    input  logic [7:0]                  i_cover_d,
    output logic                        o_valid,
    output logic [7:0]                  o_blended_sample,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sab_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    sab_pkg::t_colour r_colour [sab_pkg::NUM_LAYERS];
    logic [1:0]       r_shift;
    logic [2:0]       w_reg_idx;
    logic             w_wr;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_reg_idx = paddr[4:2];
    assign w_wr      = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sab_pkg::NUM_LAYERS; i++) begin
                r_colour[i] <= '0;
            end
            r_shift <= 2'd1;
        end else if (w_wr) begin
            unique case (w_reg_idx) inside
                sab_pkg::REG_LAYER0, sab_pkg::REG_LAYER1,
                sab_pkg::REG_LAYER2, sab_pkg::REG_LAYER3: begin
                    r_colour[w_reg_idx[1:0]] <= pwdata;
                end
                sab_pkg::REG_SHIFT: begin
                    r_shift <= pwdata[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx) inside
            sab_pkg::REG_LAYER0, sab_pkg::REG_LAYER1,
            sab_pkg::REG_LAYER2, sab_pkg::REG_LAYER3: begin
                prdata = r_colour[w_reg_idx[1:0]];
            end
            sab_pkg::REG_SHIFT: prdata = {30'd0, r_shift};
            default:            prdata = '0;
        endcase
    end

    // valid chain
    logic [sab_pkg::LATENCY-1:0] r_vld;
    logic                        w_acc;

    assign w_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[sab_pkg::LATENCY-2:0], w_acc};
        end
    end

    // stage 0: coverage selection and colour lookup
    logic [1:0]       w_shift_eff;
    logic [2:0]       w_lanes;
    logic [9:0]       w_cov_sum;
    logic [9:0]       w_cov_shr;
    logic [7:0]       w_cov;
    sab_pkg::t_colour w_col;

    always_comb begin
        w_shift_eff = (r_shift == 2'd3) ? 2'd2 : r_shift;
        w_lanes     = 3'd1 << w_shift_eff;
        if (w_lanes > 3'(sab_pkg::COVER_LANES)) begin
            w_lanes = 3'(sab_pkg::COVER_LANES);
        end
        w_cov_sum = {2'd0, i_cover_a};
        if (w_lanes > 3'd1) w_cov_sum = w_cov_sum + {2'd0, i_cover_b};
        if (w_lanes > 3'd2) w_cov_sum = w_cov_sum + {2'd0, i_cover_c};
        if (w_lanes > 3'd3) w_cov_sum = w_cov_sum + {2'd0, i_cover_d};
        w_cov_shr = w_cov_sum >> w_shift_eff;
        if (i_plane == sab_pkg::PLANE_Y) begin
            w_cov = i_cover_a;
        end else if (w_cov_shr > 10'd255) begin
            w_cov = 8'd255;
        end else begin
            w_cov = w_cov_shr[7:0];
        end
        w_col = r_colour[i_layer];
    end

    // stage 1 registers
    logic [1:0] r_s1_plane;
    logic [7:0] r_s1_d, r_s1_r, r_s1_g, r_s1_b, r_s1_cov;
    logic [8:0] r_s1_ia;

    always_ff @(posedge i_clk) begin
        r_s1_plane <= i_plane;
        r_s1_d     <= i_dest_sample;
        r_s1_r     <= w_col[23:16];
        r_s1_g     <= w_col[15:8];
        r_s1_b     <= w_col[7:0];
        r_s1_cov   <= w_cov;
        r_s1_ia    <= 9'd256 - {1'b0, w_col[31:24]};
    end

    // stage 2: luma products and coverage scaling
    logic [23:0] r_s2_pr, r_s2_pg, r_s2_pb;
    logic [7:0]  r_s2_k, r_s2_d, r_s2_r, r_s2_b;
    logic [1:0]  r_s2_plane;
    logic [16:0] w_kprod;

    assign w_kprod = 17'(r_s1_cov) * 17'(r_s1_ia);

    always_ff @(posedge i_clk) begin
        r_s2_pr    <= 24'(sab_pkg::Q_KR) * 24'(r_s1_r);
        r_s2_pg    <= 24'(sab_pkg::Q_KG) * 24'(r_s1_g);
        r_s2_pb    <= 24'(sab_pkg::Q_KB) * 24'(r_s1_b);
        r_s2_k     <= w_kprod[15:8];
        r_s2_d     <= r_s1_d;
        r_s2_r     <= r_s1_r;
        r_s2_b     <= r_s1_b;
        r_s2_plane <= r_s1_plane;
    end

    // stage 3: luma and colour difference
    logic [24:0]       w_ysum;
    logic [7:0]        w_y;
    logic [7:0]        r_s3_y, r_s3_k, r_s3_d;
    logic signed [8:0] r_s3_diff;
    logic [1:0]        r_s3_plane;

    always_comb begin
        w_ysum = {1'b0, r_s2_pr} + {1'b0, r_s2_pg} + {1'b0, r_s2_pb};
        w_y    = (w_ysum[24:16] > 9'd255) ? 8'd255 : w_ysum[23:16];
    end

    always_ff @(posedge i_clk) begin
        r_s3_y     <= w_y;
        r_s3_diff  <= (r_s2_plane == sab_pkg::PLANE_U)
                    ? $signed({1'b0, r_s2_r}) - $signed({1'b0, w_y})
                    : $signed({1'b0, r_s2_b}) - $signed({1'b0, w_y});
        r_s3_k     <= r_s2_k;
        r_s3_d     <= r_s2_d;
        r_s3_plane <= r_s2_plane;
    end

    // stage 4: chroma product
    logic signed [16:0] w_coef;
    logic signed [25:0] w_cprod;
    logic signed [26:0] r_s4_t;
    logic [7:0]         r_s4_y, r_s4_k, r_s4_d;
    logic [1:0]         r_s4_plane;

    assign w_coef  = (r_s3_plane == sab_pkg::PLANE_U) ? $signed({1'b0, sab_pkg::Q_KU})
                                                      : $signed({1'b0, sab_pkg::Q_KV});
    assign w_cprod = 26'(w_coef) * 26'(r_s3_diff);

    always_ff @(posedge i_clk) begin
        r_s4_t     <= {w_cprod[25], w_cprod} + sab_pkg::CHROMA_BIAS;
        r_s4_y     <= r_s3_y;
        r_s4_k     <= r_s3_k;
        r_s4_d     <= r_s3_d;
        r_s4_plane <= r_s3_plane;
    end

    // stage 5: plane value and mix products
    logic [7:0]  w_c;
    logic [8:0]  w_inv, w_kp1;
    logic [16:0] w_m1, w_m2;
    logic [15:0] r_s5_m1, r_s5_m2;
    logic [7:0]  r_s5_d;
    logic [1:0]  r_s5_plane;

    always_comb begin
        if (r_s4_plane == sab_pkg::PLANE_Y) begin
            w_c = r_s4_y;
        end else if (r_s4_t[26]) begin
            w_c = 8'd0;
        end else if (r_s4_t[25:24] != 2'd0) begin
            w_c = 8'd255;
        end else begin
            w_c = r_s4_t[23:16];
        end
        w_inv = 9'd256 - {1'b0, r_s4_k};
        w_kp1 = {1'b0, r_s4_k} + 9'd1;
        w_m1  = 17'(r_s4_d) * 17'(w_inv);
        w_m2  = 17'(w_c) * 17'(w_kp1);
    end

    always_ff @(posedge i_clk) begin
        r_s5_m1    <= w_m1[15:0];
        r_s5_m2    <= w_m2[15:0];
        r_s5_d     <= r_s4_d;
        r_s5_plane <= r_s4_plane;
    end

    // output stage
    logic [16:0] w_mix;
    logic [7:0]  r_out;

    assign w_mix = {1'b0, r_s5_m1} + {1'b0, r_s5_m2};

    always_ff @(posedge i_clk) begin
        case (r_s5_plane) inside
            sab_pkg::PLANE_Y, sab_pkg::PLANE_U, sab_pkg::PLANE_V: r_out <= w_mix[15:8];
            default:                                              r_out <= r_s5_d;
        endcase
    end

    assign o_valid          = r_vld[sab_pkg::LATENCY-1];
    assign o_blended_sample = r_out;

endmodule

[hdl/sab_checker.sv]
// port-level checks for the subtitle yuv alpha blend unit, bound to the top level
// depends on sab_pkg and subtitle_yuv_alpha_blend_unit

module sab_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  i_plane,
    input logic [7:0]                  i_dest_sample,
    input logic                        o_valid,
    input logic [7:0]                  o_blended_sample,
    input logic                        pready
);

    // a request always gets its result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(sab_pkg::LATENCY) o_valid)
        else $error("missing result strobe");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, sab_pkg::LATENCY))
        else $error("result strobe without request");

    // unknown plane passes the destination sample through
    a_plane_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_plane != sab_pkg::PLANE_Y && i_plane != sab_pkg::PLANE_U
         && i_plane != sab_pkg::PLANE_V)
        |-> ##(sab_pkg::LATENCY)
        (o_blended_sample == $past(i_dest_sample, sab_pkg::LATENCY)))
        else $error("unknown plane did not pass sample");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && pready)
        else $error("busy or pready wrong");

endmodule

bind subtitle_yuv_alpha_blend_unit sab_checker u_sab_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_plane          (i_plane),
    .i_dest_sample    (i_dest_sample),
    .o_valid          (o_valid),
    .o_blended_sample (o_blended_sample),
    .pready           (pready)
);
